// ===== sv/scp_pkg.sv =====
package scp_pkg;

  localparam int OUT_NUM_W = 16;

  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_UP_S  = 8'h53;
  localparam logic [7:0] CH_LO_S  = 8'h73;
  localparam logic [7:0] CH_UP_L  = 8'h4C;
  localparam logic [7:0] CH_LO_L  = 8'h6C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic EV_DONE    = 1'b0;
  localparam logic EV_BAD     = 1'b1;
  localparam logic CMD_STATUS = 1'b0;
  localparam logic CMD_LED    = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_WAIT1 = 5'b00010,
    ST_COLL1 = 5'b00100,
    ST_WAIT2 = 5'b01000,
    ST_COLL2 = 5'b10000
  } state_t;

  typedef struct packed {
    state_t state;
    logic   pending_cmd;
  } ctrl_t;

  typedef struct packed {
    logic                 emit;
    logic                 event_kind;
    logic                 cmd_code;
    logic [OUT_NUM_W-1:0] first_number;
    logic [OUT_NUM_W-1:0] second_number;
    logic [7:0]           bad_byte;
  } evt_t;

endpackage

// ===== sv/scp_rx_if.sv =====
interface scp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== sv/scp_evt_if.sv =====
interface scp_evt_if;
  logic                         valid;
  logic                         ready;
  logic                         event_kind;
  logic                         cmd_code;
  logic [scp_pkg::OUT_NUM_W-1:0] first_number;
  logic [scp_pkg::OUT_NUM_W-1:0] second_number;
  logic [7:0]                   bad_byte;

  modport source (output valid, output event_kind, output cmd_code, output first_number,
                  output second_number, output bad_byte, input ready);
  modport sink (input valid, input event_kind, input cmd_code, input first_number,
                input second_number, input bad_byte, output ready);
endinterface

// ===== sv/scp_step.sv =====
module scp_step #(
  parameter int NUMBER_WIDTH = 16
) (
  input  logic [7:0]              rx_byte,
  input  scp_pkg::ctrl_t          ctrl,
  input  logic [NUMBER_WIDTH-1:0] acc_first,
  input  logic [NUMBER_WIDTH-1:0] acc_second,
  output scp_pkg::ctrl_t          ctrl_nxt,
  output logic [NUMBER_WIDTH-1:0] acc_first_nxt,
  output logic [NUMBER_WIDTH-1:0] acc_second_nxt,
  output scp_pkg::evt_t           evt
);

  localparam int PW = NUMBER_WIDTH + 4;

  // acc * 10 + d, clamped to all ones
  function automatic logic [NUMBER_WIDTH-1:0] push_digit(input logic [NUMBER_WIDTH-1:0] a,
                                                         input logic [3:0] d);
    logic [PW-1:0] v;
    v = (PW'(a) << 3) + (PW'(a) << 1) + PW'(d);
    if (|v[PW-1:NUMBER_WIDTH]) return '1;
    return v[NUMBER_WIDTH-1:0];
  endfunction

  logic       is_digit;
  logic       is_esc;
  logic [7:0] diff;
  logic [3:0] digit;
  logic [31:0] first_ext;
  logic [31:0] second_ext;

  assign is_esc    = (rx_byte == scp_pkg::CH_ESC);
  assign is_digit  = (rx_byte >= scp_pkg::CH_ZERO) && (rx_byte <= scp_pkg::CH_NINE);
  assign diff      = rx_byte - scp_pkg::CH_ZERO;
  assign digit     = diff[3:0];
  assign first_ext  = 32'(acc_first);
  assign second_ext = 32'(acc_second);

  always_comb begin
    ctrl_nxt       = ctrl;
    acc_first_nxt  = acc_first;
    acc_second_nxt = acc_second;
    evt            = '0;
    unique case (ctrl.state)
      scp_pkg::ST_WAIT1: begin
        if (is_esc) begin
          ctrl_nxt.state = scp_pkg::ST_IDLE;
        end else if (is_digit) begin
          acc_first_nxt  = NUMBER_WIDTH'(digit);
          ctrl_nxt.state = scp_pkg::ST_COLL1;
        end
      end
      scp_pkg::ST_COLL1: begin
        if (is_esc) begin
          ctrl_nxt.state = scp_pkg::ST_IDLE;
        end else if (is_digit) begin
          acc_first_nxt = push_digit(acc_first, digit);
        end else begin
          ctrl_nxt.state = scp_pkg::ST_WAIT2;
        end
      end
      scp_pkg::ST_WAIT2: begin
        if (is_esc) begin
          ctrl_nxt.state = scp_pkg::ST_IDLE;
        end else if (is_digit) begin
          acc_second_nxt = NUMBER_WIDTH'(digit);
          ctrl_nxt.state = scp_pkg::ST_COLL2;
        end
      end
      scp_pkg::ST_COLL2: begin
        if (is_esc) begin
          ctrl_nxt.state = scp_pkg::ST_IDLE;
        end else if (is_digit) begin
          acc_second_nxt = push_digit(acc_second, digit);
        end else begin
          // terminator completes the command
          ctrl_nxt.state    = scp_pkg::ST_IDLE;
          evt.emit          = 1'b1;
          evt.event_kind    = scp_pkg::EV_DONE;
          evt.cmd_code      = ctrl.pending_cmd;
          evt.first_number  = first_ext[scp_pkg::OUT_NUM_W-1:0];
          evt.second_number = second_ext[scp_pkg::OUT_NUM_W-1:0];
        end
      end
      default: begin
        // idle, and any stray code falls back here
        ctrl_nxt.state = scp_pkg::ST_IDLE;
        if (is_esc || rx_byte == scp_pkg::CH_CR || rx_byte == scp_pkg::CH_LF) begin
          ctrl_nxt.state = scp_pkg::ST_IDLE;
        end else if (rx_byte == scp_pkg::CH_UP_S || rx_byte == scp_pkg::CH_LO_S) begin
          ctrl_nxt.pending_cmd = scp_pkg::CMD_STATUS;
          ctrl_nxt.state       = scp_pkg::ST_COLL2;
        end else if (rx_byte == scp_pkg::CH_UP_L || rx_byte == scp_pkg::CH_LO_L) begin
          ctrl_nxt.pending_cmd = scp_pkg::CMD_LED;
          acc_second_nxt       = '0;
          ctrl_nxt.state       = scp_pkg::ST_WAIT1;
        end else begin
          evt.emit       = 1'b1;
          evt.event_kind = scp_pkg::EV_BAD;
          evt.bad_byte   = rx_byte;
        end
      end
    endcase
  end

endmodule

// ===== sv/serial_command_parser.sv =====
// channel | dir | payload                                                  | handshake
// in_ch   | in  | rx_byte[7:0]                                             | valid/ready
// out_ch  | out | event_kind, cmd_code, first_number, second_number, bad_byte | valid/ready
//
// one byte per cycle sustained unless a result stalls; a byte is registered on entry and
// parsed when the parse step advances, any result it yields going into the result register
// rst_n is synchronous active low; it returns the parser to idle with both numbers zero
// a stalled result holds the parse step, which holds the input register; input stays
// open while the input register is empty or its byte moves on in the same cycle
module serial_command_parser #(
  parameter int NUMBER_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  scp_rx_if.sink    in_ch,
  scp_evt_if.source out_ch
);

  logic [7:0]              byte_r;
  logic                    byte_vld_r;
  scp_pkg::ctrl_t          ctrl_r;
  scp_pkg::ctrl_t          ctrl_nxt;
  logic [NUMBER_WIDTH-1:0] acc_first_r;
  logic [NUMBER_WIDTH-1:0] acc_first_nxt;
  logic [NUMBER_WIDTH-1:0] acc_second_r;
  logic [NUMBER_WIDTH-1:0] acc_second_nxt;
  scp_pkg::evt_t           evt;
  scp_pkg::evt_t           out_r;
  logic                    out_vld_r;
  logic                    advance;

  assign advance     = byte_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !byte_vld_r || advance;

  scp_step #(
    .NUMBER_WIDTH(NUMBER_WIDTH)
  ) u_step (
    .rx_byte        (byte_r),
    .ctrl           (ctrl_r),
    .acc_first      (acc_first_r),
    .acc_second     (acc_second_r),
    .ctrl_nxt       (ctrl_nxt),
    .acc_first_nxt  (acc_first_nxt),
    .acc_second_nxt (acc_second_nxt),
    .evt            (evt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r   <= 1'b0;
      out_vld_r    <= 1'b0;
      ctrl_r       <= '{state: scp_pkg::ST_IDLE, pending_cmd: scp_pkg::CMD_STATUS};
      acc_first_r  <= '0;
      acc_second_r <= '0;
    end else begin
      if (in_ch.ready) begin
        byte_vld_r <= in_ch.valid;
      end
      // a new result replaces a drained one in the same cycle
      if (advance && evt.emit) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
      if (advance) begin
        ctrl_r       <= ctrl_nxt;
        acc_first_r  <= acc_first_nxt;
        acc_second_r <= acc_second_nxt;
      end
    end
  end

  // payload words, no reset
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      byte_r <= in_ch.rx_byte;
    end
    if (advance && evt.emit) begin
      out_r <= evt;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.event_kind    = out_r.event_kind;
  assign out_ch.cmd_code      = out_r.cmd_code;
  assign out_ch.first_number  = out_r.first_number;
  assign out_ch.second_number = out_r.second_number;
  assign out_ch.bad_byte      = out_r.bad_byte;

  a_rise_from_byte: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(byte_vld_r))
    else $error("result appeared with no byte in the parse stage");

  a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.event_kind == scp_pkg::EV_BAD |->
      out_r.first_number == '0 && out_r.second_number == '0 &&
      out_r.cmd_code == scp_pkg::CMD_STATUS)
    else $error("unrecognised byte word carries command fields");

  a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.event_kind == scp_pkg::EV_DONE |-> out_r.bad_byte == 8'h00)
    else $error("completed command word carries a bad byte");

  a_esc_idle: assert property (@(posedge clk) disable iff (!rst_n)
    advance && byte_r == scp_pkg::CH_ESC |=> ctrl_r.state == scp_pkg::ST_IDLE)
    else $error("escape did not return the parser to idle");

  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    advance && evt.emit |=> ctrl_r.state == scp_pkg::ST_IDLE)
    else $error("parser left idle after emitting a result");

endmodule
